[hdl/magnetometer_heading_atan2_unit_assert.svh]
// Assertion macros for the magnetometer heading unit.
// Used by the port-level checker; no other dependencies.
`ifndef MAGNETOMETER_HEADING_ATAN2_UNIT_ASSERT_SVH
`define MAGNETOMETER_HEADING_ATAN2_UNIT_ASSERT_SVH

// Cause now implies effect in the next cycle, ignored while in reset.
`define MHA_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

// Condition implies check in the same cycle, ignored while in reset.
`define MHA_ASSERT_NOW(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Cause implies effect in the next cycle, also checked across reset.
`define MHA_ASSERT_NEXT_ALWAYS(label, clk, cause, effect, msg) \
    label: assert property (@(posedge clk) (cause) |=> (effect)) \
        else $error(msg);

`endif

[hdl/mha_pkg.sv]
// Shared types and constants for the magnetometer heading unit.
// Angle formats, turn constants and the CORDIC arctangent table.
package mha_pkg;

    localparam int GUARD_BITS   = 24;
    localparam int ANGLE_W      = 22;
    localparam int OFFSET_W     = 14;
    localparam int FRAC_BITS    = 8;
    localparam int WRAP_W       = 25;
    localparam int TURN_W       = 23;
    localparam int HEADING_W    = 13;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(737280);

    localparam logic [TURN_W-1:0] FULL_TURN_1 = TURN_W'(1474560);
    localparam logic [TURN_W-1:0] FULL_TURN_2 = TURN_W'(2949120);
    localparam logic [TURN_W-1:0] FULL_TURN_3 = TURN_W'(4423680);

    // two full turns minus a quarter turn plus half an output LSB
    localparam logic signed [WRAP_W-1:0] WRAP_BIAS = WRAP_W'(2580608);

    localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        ANGLE_W'(184320), ANGLE_W'(108810), ANGLE_W'(57492), ANGLE_W'(29184),
        ANGLE_W'(14649),  ANGLE_W'(7331),   ANGLE_W'(3667),  ANGLE_W'(1833),
        ANGLE_W'(917),    ANGLE_W'(458),    ANGLE_W'(229),   ANGLE_W'(115),
        ANGLE_W'(57),     ANGLE_W'(29),     ANGLE_W'(14),    ANGLE_W'(7),
        ANGLE_W'(4),      ANGLE_W'(2),      ANGLE_W'(1),     ANGLE_W'(0),
        ANGLE_W'(0),      ANGLE_W'(0),      ANGLE_W'(0),     ANGLE_W'(0)
    };

    typedef struct packed {
        logic                      zero;
        logic signed [ANGLE_W-1:0] z;
    } angle_t;

    function automatic logic signed [ANGLE_W-1:0] atan_entry(input int idx);
        if (idx < ATAN_ENTRIES) begin
            return ATAN_TABLE[idx];
        end
        return '0;
    endfunction

endpackage

[hdl/magnetometer_heading_atan2_unit.sv]
// Compass heading from X/Y magnetometer samples via a pipelined vectoring CORDIC.
// Pipeline registers: input fold, one per iteration, two output.
// Throughput: one sample per cycle while the output is not stalled; each CORDIC iteration owns a register stage.
// Ready ripples back per stage, so bubbles fill while the output transfer stalls.
// Reset (aresetn low, synchronous) empties all stages and clears the offset register.
// Depends on mha_pkg, mha_prep, mha_cordic_stage and mha_wrap.
module magnetometer_heading_atan2_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic signed [mha_pkg::OFFSET_W-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_field_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_field_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mha_pkg::HEADING_W-1:0]        m_heading_angle
);
    import mha_pkg::*;

    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;

    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       valid_pipe [CORDIC_STAGES+1];
    logic                       ready_pipe [CORDIC_STAGES+1];
    logic signed [DW-1:0]       x_pipe     [CORDIC_STAGES+1];
    logic signed [DW-1:0]       y_pipe     [CORDIC_STAGES+1];
    angle_t                     a_pipe     [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_we) begin
            offset_reg <= cfg_wdata;
        end
    end

    mha_prep #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DW           (DW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .field_x   (s_field_x),
        .field_y   (s_field_y),
        .out_valid (valid_pipe[0]),
        .out_ready (ready_pipe[0]),
        .x_out     (x_pipe[0]),
        .y_out     (y_pipe[0]),
        .a_out     (a_pipe[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        mha_cordic_stage #(
            .DW    (DW),
            .SHIFT (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_pipe[i]),
            .in_ready  (ready_pipe[i]),
            .x_in      (x_pipe[i]),
            .y_in      (y_pipe[i]),
            .a_in      (a_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_ready (ready_pipe[i+1]),
            .x_out     (x_pipe[i+1]),
            .y_out     (y_pipe[i+1]),
            .a_out     (a_pipe[i+1])
        );
    end

    mha_wrap u_wrap (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (valid_pipe[CORDIC_STAGES]),
        .in_ready       (ready_pipe[CORDIC_STAGES]),
        .a_in           (a_pipe[CORDIC_STAGES]),
        .trim_offset    (offset_reg),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .heading_angle  (m_heading_angle)
    );

endmodule

[hdl/mha_prep.sv]
// Input stage: sign-extend and scale the sample, fold the left half plane.
// Depends on mha_pkg.
module mha_prep #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DW           = 43
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] field_x,
    input  logic signed [SAMPLE_WIDTH-1:0] field_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DW-1:0]          x_out,
    output logic signed [DW-1:0]          y_out,
    output mha_pkg::angle_t               a_out
);
    import mha_pkg::*;

    localparam int EXT_W = DW - SAMPLE_WIDTH - GUARD_BITS;

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    angle_t               a_reg, a_next;
    logic signed [DW-1:0] x_wide, y_wide;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        x_wide = $signed({{EXT_W{field_x[SAMPLE_WIDTH-1]}}, field_x, {GUARD_BITS{1'b0}}});
        y_wide = $signed({{EXT_W{field_y[SAMPLE_WIDTH-1]}}, field_y, {GUARD_BITS{1'b0}}});
        a_next.zero = (field_x == '0) && (field_y == '0);
        if (field_x[SAMPLE_WIDTH-1]) begin
            x_next  = -x_wide;
            y_next  = -y_wide;
            a_next.z = HALF_TURN;
        end else begin
            x_next  = x_wide;
            y_next  = y_wide;
            a_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg <= x_next;
            y_reg <= y_next;
            a_reg <= a_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign a_out     = a_reg;

endmodule

[hdl/mha_cordic_stage.sv]
// One vectoring CORDIC iteration with its pipeline register.
// Depends on mha_pkg for the angle type and arctangent table.
module mha_cordic_stage #(
    parameter int DW    = 43,
    parameter int SHIFT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  mha_pkg::angle_t      a_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output mha_pkg::angle_t      a_out
);
    import mha_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ATAN_STEP = atan_entry(SHIFT);

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    angle_t               a_reg, a_next;
    logic signed [DW-1:0] xs, ys;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xs = x_in >>> SHIFT;
        ys = y_in >>> SHIFT;
        a_next.zero = a_in.zero;
        if (!y_in[DW-1]) begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            a_next.z = a_in.z + ATAN_STEP;
        end else begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            a_next.z = a_in.z - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg <= x_next;
            y_reg <= y_next;
            a_reg <= a_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign a_out     = a_reg;

endmodule

[hdl/mha_wrap.sv]
// Output stages: add offset and bias, then wrap into one turn and round.
// Depends on mha_pkg for the angle type and turn constants.
module mha_wrap (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mha_pkg::angle_t                      a_in,
    input  logic signed [mha_pkg::OFFSET_W-1:0]  trim_offset,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mha_pkg::HEADING_W-1:0]        heading_angle
);
    import mha_pkg::*;

    logic                      sum_valid_reg;
    logic [TURN_W-1:0]         sum_reg, sum_next;
    logic                      sum_ready;
    logic                      out_valid_reg;
    logic [HEADING_W-1:0]      heading_reg, heading_next;
    logic signed [WRAP_W-1:0]  z_ext, off_ext, total;
    logic [TURN_W-1:0]         rem;

    assign sum_ready = !out_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;

    always_comb begin
        if (a_in.zero) begin
            z_ext = '0;
        end else begin
            z_ext = {{(WRAP_W-ANGLE_W){a_in.z[ANGLE_W-1]}}, a_in.z};
        end
        off_ext = {{(WRAP_W-OFFSET_W-FRAC_BITS){trim_offset[OFFSET_W-1]}},
                   trim_offset, {FRAC_BITS{1'b0}}};
        total    = z_ext + off_ext + WRAP_BIAS;
        sum_next = total[TURN_W-1:0];
    end

    always_comb begin
        if (sum_reg >= FULL_TURN_3) begin
            rem = sum_reg - FULL_TURN_3;
        end else if (sum_reg >= FULL_TURN_2) begin
            rem = sum_reg - FULL_TURN_2;
        end else if (sum_reg >= FULL_TURN_1) begin
            rem = sum_reg - FULL_TURN_1;
        end else begin
            rem = sum_reg;
        end
        heading_next = rem[FRAC_BITS+HEADING_W-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && sum_ready) begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign heading_angle = heading_reg;

endmodule

[hdl/mha_checker.sv]
// Port-level checker for the magnetometer heading unit, bound to the top level.
// Depends on magnetometer_heading_atan2_unit_assert.svh.
`include "magnetometer_heading_atan2_unit_assert.svh"

module mha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [12:0] m_heading_angle
);

    `MHA_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid,
                     "result dropped while stalled")
    `MHA_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready,
                     $stable(m_heading_angle), "result changed while stalled")
    `MHA_ASSERT_NOW(a_range, aclk, aresetn, m_valid, m_heading_angle < 13'd5760,
                    "heading outside one turn")
    `MHA_ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind magnetometer_heading_atan2_unit mha_checker u_mha_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_heading_angle (m_heading_angle)
);

[bench/testbench.sv]
// Testbench for magnetometer_heading_atan2_unit: directed and random X/Y samples
// under several heading offsets, with random stalls on both channels.
// Depends on mha_pkg for widths; the expected headings come from a local CORDIC model.
module testbench;

    import mha_pkg::*;

    localparam int STAGES      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int LATENCY     = STAGES + 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint FULL_CIRCLE    = 64'd1474560;
    localparam longint HALF_CIRCLE    = 64'd737280;
    localparam longint QUARTER_CIRCLE = 64'd368640;
    localparam longint ARCTAN_DEG [24] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0, 0, 0, 0
    };

    logic                         aclk            = 1'b0;
    logic                         aresetn         = 1'b0;
    logic                         cfg_we          = 1'b0;
    logic signed [OFFSET_W-1:0]   cfg_wdata       = '0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_field_x       = '0;
    logic signed [SAMPLE_W-1:0]   s_field_y       = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic [HEADING_W-1:0]         m_heading_angle;

    logic [HEADING_W-1:0]         expected_headings [$];
    logic signed [OFFSET_W-1:0]   offset_model    = '0;
    bit                           idle_on         = 1'b1;
    int                           heading_errors  = 0;
    int                           stall_left      = 0;
    longint                       cycle_count     = 0;

    magnetometer_heading_atan2_unit #(
        .CORDIC_STAGES (STAGES),
        .SAMPLE_WIDTH  (SAMPLE_W)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_field_x       (s_field_x),
        .s_field_y       (s_field_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_heading_angle (m_heading_angle)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [HEADING_W-1:0] predict_heading(
        input logic signed [SAMPLE_W-1:0] fx,
        input logic signed [SAMPLE_W-1:0] fy,
        input logic signed [OFFSET_W-1:0] ofs
    );
        longint x, y, z, xs, ys, sum, rem, ofs_l;
        x = fx;
        y = fy;
        z = 0;
        ofs_l = ofs;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_CIRCLE;
            end
            x = x * (64'sd1 <<< GUARD_BITS);
            y = y * (64'sd1 <<< GUARD_BITS);
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ((i < 24) ? ARCTAN_DEG[i] : 0);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ((i < 24) ? ARCTAN_DEG[i] : 0);
                end
            end
        end
        sum = z - QUARTER_CIRCLE + ofs_l * 256 + 128;
        rem = sum % FULL_CIRCLE;
        if (rem < 0) begin
            rem = rem + FULL_CIRCLE;
        end
        return HEADING_W'(rem >>> 8);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_reading();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            6, 7: v = SAMPLE_W'($signed($urandom_range(0, 32)) - 16);
            8: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            9: v = '0;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_headings.size() == 0) begin
                $error("unexpected transfer: heading_angle actual %0d", m_heading_angle);
                heading_errors++;
            end else begin
                if (m_heading_angle !== expected_headings[0]) begin
                    $error("heading_angle mismatch: expected %0d actual %0d",
                           expected_headings[0], m_heading_angle);
                    heading_errors++;
                end
                void'(expected_headings.pop_front());
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            s_field_x = SAMPLE_W'($urandom);
            s_field_y = SAMPLE_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_field_x = x;
        s_field_y = y;
        do @(posedge aclk); while (!s_ready);
        expected_headings.push_back(predict_heading(x, y, offset_model));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_headings.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(posedge aclk);
        offset_model = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic test_directed_samples();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(16'sd0, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(-16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd100, 16'sd100);
        send_sample(-16'sd5, 16'sd3);
        drain();
    endtask

    task automatic test_offset_extremes();
        logic signed [OFFSET_W-1:0] extremes [6];
        extremes = '{-14'sd5760, 14'sd5760, 14'sh2000, 14'sh1FFF, 14'sd1, 14'sd0};
        foreach (extremes[k]) begin
            write_offset(extremes[k]);
            send_sample(16'sd0, 16'sd0);
            send_sample(16'sh8000, 16'sd0);
            send_sample(16'sd0, 16'sh7FFF);
            send_sample(16'sh7FFF, 16'sh8000);
        end
        drain();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) begin
                write_offset(-14'sd5760);
            end else begin
                write_offset(OFFSET_W'($urandom));
            end
            repeat (85) send_sample(random_reading(), random_reading());
        end
        drain();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        write_offset(14'sd5760);
        repeat (40) send_sample(random_reading(), random_reading());
        write_offset(OFFSET_W'($urandom_range(0, 11520)) - 14'sd5760);
        repeat (40) send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_samples();
        test_offset_extremes();
        test_random_phases();
        test_full_rate();
        repeat (2 * LATENCY) @(posedge aclk);
        if (heading_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
